// ===== src/idq_pkg.sv =====
// Shared types and field widths for the indexed double-ended queue.
`timescale 1ns / 1ps

package idq_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 10;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic load_read;
    } dp_cmd_t;

    typedef struct packed {
        logic read_hit;
    } dp_status_t;

endpackage

// ===== src/idq_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/idq_ctrl.sv =====
// Controller: accepts one beat, waits on the RAM read when a read hits, holds the result.
`timescale 1ns / 1ps

module idq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  idq_pkg::dp_status_t stat,
    output idq_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept        = in_valid && (state_reg == S_IDLE);
    assign cmd.accept    = accept;
    assign cmd.load_read = (state_reg == S_READ);
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_HOLD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.read_hit ? S_READ : S_HOLD;
                end
            end
            S_READ:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/idq_datapath.sv =====
// Datapath: front pointer, count, ring slot arithmetic, element RAM, result registers.
`timescale 1ns / 1ps

module idq_datapath #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  idq_pkg::dp_cmd_t                  cmd,
    output idq_pkg::dp_status_t               stat,
    input  logic [idq_pkg::OPCODE_W-1:0]      opcode,
    input  logic [idq_pkg::POS_W-1:0]         position,
    input  logic [idq_pkg::ITEM_W-1:0]        item_value,
    output logic [idq_pkg::ITEM_W-1:0]        read_value,
    output logic [idq_pkg::STATUS_W-1:0]      status,
    output logic [idq_pkg::COUNT_W-1:0]       element_count
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = idq_pkg::POS_W;
    localparam int ITEM_W    = idq_pkg::ITEM_W;
    localparam int OUT_CNT_W = idq_pkg::COUNT_W;
    localparam int SUM_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [PTR_W-1:0]      front_reg;
    logic [PTR_W-1:0]      front_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    idq_pkg::status_t      status_reg;
    idq_pkg::status_t      status_next;
    logic [ITEM_W-1:0]     read_value_reg;

    idq_pkg::opcode_t      op;
    logic                  full;
    logic                  empty;
    logic                  in_range;
    logic [SUM_W-1:0]      offset;
    logic [SUM_W-1:0]      sum;
    logic [PTR_W-1:0]      slot;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      front_inc;
    logic                  mem_en;
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_addr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  read_hit;

    assign op        = idq_pkg::opcode_t'(opcode);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign in_range  = (SUM_W'(position) < SUM_W'(count_reg));
    assign offset    = ((op == idq_pkg::OP_READ) || (op == idq_pkg::OP_WRITE))
                       ? SUM_W'(position) : SUM_W'(count_reg);
    assign sum       = SUM_W'(front_reg) + offset;
    assign slot      = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : (front_reg - PTR_W'(1));
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : (front_reg + PTR_W'(1));
    assign mem_wdata = VALUE_BITS'(item_value);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = idq_pkg::ST_OK;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = slot;
        read_hit    = 1'b0;
        unique case (op)
            idq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = idq_pkg::ST_FULL;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            idq_pkg::OP_POP_BACK:
            begin
                if (!empty)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            idq_pkg::OP_PUSH_FRONT:
            begin
                mem_addr = front_dec;
                if (full)
                begin
                    status_next = idq_pkg::ST_FULL;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            idq_pkg::OP_POP_FRONT:
            begin
                if (!empty)
                begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            idq_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    mem_en   = 1'b1;
                    read_hit = 1'b1;
                end
                else
                begin
                    status_next = idq_pkg::ST_RANGE;
                end
            end
            idq_pkg::OP_WRITE:
            begin
                if (in_range)
                begin
                    mem_en = 1'b1;
                    mem_we = 1'b1;
                end
                else
                begin
                    status_next = idq_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_next = idq_pkg::ST_OK;
            end
        endcase
    end

    idq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en && cmd.accept),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= '0;
        end
        else if (cmd.load_read)
        begin
            read_value_reg <= ITEM_W'(mem_rdata);
        end
    end

    assign stat.read_hit  = read_hit;
    assign read_value     = read_value_reg;
    assign status         = status_reg;
    assign element_count  = OUT_CNT_W'(count_reg);

endmodule

// ===== src/indexed_double_ended_queue.sv =====
// Top level of the indexed double-ended queue on a ring-buffer RAM.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall  | opcode, position, item_value
//  out     | source    | out_valid / out_stall| read_value, status, element_count
//
// One beat in gives one beat out. The result is valid the cycle after the accept;
// a read that hits first passes through S_READ (RAM registered read). The block holds
// one request at a time and takes the next beat the cycle after the result leaves.
// Reset clears the front pointer and count; RAM contents are left as is.
// out_stall holds the result and keeps in_stall high.
`timescale 1ns / 1ps

module indexed_double_ended_queue #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [idq_pkg::OPCODE_W-1:0] opcode,
    input  logic [idq_pkg::POS_W-1:0]    position,
    input  logic [idq_pkg::ITEM_W-1:0]   item_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [idq_pkg::ITEM_W-1:0]   read_value,
    output logic [idq_pkg::STATUS_W-1:0] status,
    output logic [idq_pkg::COUNT_W-1:0]  element_count
);

    localparam int OUT_CNT_W = idq_pkg::COUNT_W;

    idq_pkg::dp_cmd_t    cmd;
    idq_pkg::dp_status_t stat;

    idq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    idq_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .position      (position),
        .item_value    (item_value),
        .read_value    (read_value),
        .status        (status),
        .element_count (element_count)
    );

`ifndef SYNTHESIS
    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("input beat taken while a result is pending");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second beat taken before result delivered");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == idq_pkg::ST_FULL)) |-> (element_count == OUT_CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == idq_pkg::ST_RANGE)) |-> (read_value == '0))
        else $error("out-of-range result carries data");
`endif

endmodule

// ===== verif/indexed_double_ended_queue_tb.sv =====
// Testbench for the indexed double-ended queue: directed, random and fill-to-full traffic.
`timescale 1ns / 1ps

module indexed_double_ended_queue_tb;

    localparam int QUEUE_DEPTH  = 1024;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [idq_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [idq_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [idq_pkg::ITEM_W-1:0]   read_value;
        logic [idq_pkg::STATUS_W-1:0] status;
        logic [idq_pkg::COUNT_W-1:0]  element_count;
    } deque_result_t;

    logic                         clk;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic [idq_pkg::OPCODE_W-1:0] opcode     = '0;
    logic [idq_pkg::POS_W-1:0]    position   = '0;
    logic [idq_pkg::ITEM_W-1:0]   item_value = '0;
    logic                         out_valid;
    logic                         out_stall  = 1'b0;
    logic [idq_pkg::ITEM_W-1:0]   read_value;
    logic [idq_pkg::STATUS_W-1:0] status;
    logic [idq_pkg::COUNT_W-1:0]  element_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;

    deque_result_t              due_results[$];
    logic [idq_pkg::ITEM_W-1:0] ring_mem [QUEUE_DEPTH];
    logic [idq_pkg::POS_W-1:0]  head_idx = '0;
    logic [idq_pkg::COUNT_W-1:0] held    = '0;

    indexed_double_ended_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .VALUE_BITS (idq_pkg::ITEM_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .position      (position),
        .item_value    (item_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .element_count (element_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [idq_pkg::ITEM_W-1:0] want,
                                   input logic [idq_pkg::ITEM_W-1:0] got);
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Ring-buffer deque; queues the result the block owes for this beat.
    task automatic deque_step(input logic [idq_pkg::OPCODE_W-1:0] op,
                              input logic [idq_pkg::POS_W-1:0] pos,
                              input logic [idq_pkg::ITEM_W-1:0] val);
        deque_result_t r;
        logic [idq_pkg::POS_W-1:0] slot;
        r.read_value = '0;
        r.status     = idq_pkg::ST_OK;
        case (op)
            idq_pkg::OP_PUSH_BACK:
                if (held == QUEUE_DEPTH)
                    r.status = idq_pkg::ST_FULL;
                else
                begin
                    slot = head_idx + held[idq_pkg::POS_W-1:0];
                    ring_mem[slot] = val;
                    held++;
                end
            idq_pkg::OP_POP_BACK:
                if (held != 0)
                    held--;
            idq_pkg::OP_PUSH_FRONT:
                if (held == QUEUE_DEPTH)
                    r.status = idq_pkg::ST_FULL;
                else
                begin
                    head_idx = head_idx - 1'b1;
                    ring_mem[head_idx] = val;
                    held++;
                end
            idq_pkg::OP_POP_FRONT:
                if (held != 0)
                begin
                    head_idx = head_idx + 1'b1;
                    held--;
                end
            idq_pkg::OP_READ:
                if ({1'b0, pos} >= held)
                    r.status = idq_pkg::ST_RANGE;
                else
                begin
                    slot = head_idx + pos;
                    r.read_value = ring_mem[slot];
                end
            idq_pkg::OP_WRITE:
                if ({1'b0, pos} >= held)
                    r.status = idq_pkg::ST_RANGE;
                else
                begin
                    slot = head_idx + pos;
                    ring_mem[slot] = val;
                end
            default:
                ;
        endcase
        r.element_count = held;
        due_results.push_back(r);
    endtask

    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
                report_mismatch("result beat with nothing pending", '0, read_value);
            else
            begin
                want = due_results.pop_front();
                if (read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, read_value);
                if (status !== want.status)
                    report_mismatch("status", idq_pkg::ITEM_W'(want.status),
                                    idq_pkg::ITEM_W'(status));
                if (element_count !== want.element_count)
                    report_mismatch("element_count", idq_pkg::ITEM_W'(want.element_count),
                                    idq_pkg::ITEM_W'(element_count));
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_beat(input logic [idq_pkg::OPCODE_W-1:0] op,
                             input logic [idq_pkg::POS_W-1:0] pos,
                             input logic [idq_pkg::ITEM_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode     <= op;
        position   <= pos;
        item_value <= val;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        deque_step(op, pos, val);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    function automatic logic [idq_pkg::ITEM_W-1:0] pick_value();
        int k;
        k = $urandom_range(99);
        if (k < 5)
            return '0;
        if (k < 10)
            return '1;
        return $urandom();
    endfunction

    // Mostly in range, some right at the end, some anywhere.
    function automatic logic [idq_pkg::POS_W-1:0] pick_position();
        int k;
        k = $urandom_range(99);
        if (held != 0 && k < 70)
            return idq_pkg::POS_W'($urandom_range(int'(held) - 1));
        if (k < 85)
            return idq_pkg::POS_W'(int'(held) + $urandom_range(3));
        return idq_pkg::POS_W'($urandom_range(QUEUE_DEPTH - 1));
    endfunction

    task automatic test_basic_and_empty();
        send_beat(idq_pkg::OP_POP_BACK, '0, '1);
        send_beat(idq_pkg::OP_POP_FRONT, '1, '0);
        send_beat(idq_pkg::OP_READ, '0, '0);
        send_beat(idq_pkg::OP_WRITE, '0, '1);
        send_beat(idq_pkg::OP_PUSH_BACK, '0, '1);
        send_beat(idq_pkg::OP_PUSH_FRONT, '1, '0);
        send_beat(idq_pkg::OP_PUSH_BACK, '0, 32'hA5A5_5A5A);
        send_beat(idq_pkg::OP_READ, 10'd0, '0);
        send_beat(idq_pkg::OP_READ, 10'd1, '0);
        send_beat(idq_pkg::OP_READ, 10'd2, '0);
        send_beat(idq_pkg::OP_READ, 10'd3, '0);
        send_beat(idq_pkg::OP_READ, '1, '0);
        send_beat(idq_pkg::OP_WRITE, 10'd1, 32'h5A5A_A5A5);
        send_beat(idq_pkg::OP_READ, 10'd1, '1);
        send_beat(idq_pkg::OP_WRITE, '1, '1);
        send_beat(OP_SPARE_6, '1, '1);
        send_beat(OP_SPARE_7, '0, '1);
        send_beat(idq_pkg::OP_POP_BACK, '0, '0);
        send_beat(idq_pkg::OP_POP_FRONT, '0, '0);
        send_beat(idq_pkg::OP_READ, 10'd0, '0);
        send_beat(idq_pkg::OP_POP_FRONT, '0, '0);
        send_beat(idq_pkg::OP_POP_BACK, '0, '0);
        send_beat(idq_pkg::OP_READ, 10'd0, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int beats);
        int k;
        logic [idq_pkg::OPCODE_W-1:0] op;
        repeat (beats)
        begin
            k = $urandom_range(99);
            if (k < 20)
                op = idq_pkg::OP_PUSH_BACK;
            else if (k < 35)
                op = idq_pkg::OP_PUSH_FRONT;
            else if (k < 47)
                op = idq_pkg::OP_POP_BACK;
            else if (k < 59)
                op = idq_pkg::OP_POP_FRONT;
            else if (k < 77)
                op = idq_pkg::OP_READ;
            else if (k < 94)
                op = idq_pkg::OP_WRITE;
            else if (k < 97)
                op = OP_SPARE_6;
            else
                op = OP_SPARE_7;
            send_beat(op, pick_position(), pick_value());
            if ($urandom_range(99) < 3)
                wait_idle();
        end
        wait_idle();
    endtask

    task automatic test_full_store();
        int k;
        logic [idq_pkg::OPCODE_W-1:0] op;
        while (held < QUEUE_DEPTH)
        begin
            k = $urandom_range(99);
            if (k < 45)
                op = idq_pkg::OP_PUSH_BACK;
            else if (k < 90)
                op = idq_pkg::OP_PUSH_FRONT;
            else if (k < 94)
                op = idq_pkg::OP_READ;
            else if (k < 97)
                op = idq_pkg::OP_WRITE;
            else if (k < 98)
                op = OP_SPARE_6;
            else if (k < 99)
                op = OP_SPARE_7;
            else
                op = idq_pkg::OP_POP_BACK;
            send_beat(op, pick_position(), pick_value());
        end
        send_beat(idq_pkg::OP_PUSH_BACK, '0, pick_value());
        send_beat(idq_pkg::OP_PUSH_FRONT, '1, pick_value());
        send_beat(idq_pkg::OP_READ, '0, '0);
        send_beat(idq_pkg::OP_READ, '1, '0);
        send_beat(idq_pkg::OP_WRITE, '1, '1);
        send_beat(idq_pkg::OP_READ, '1, '0);
        send_beat(idq_pkg::OP_POP_FRONT, '0, '0);
        send_beat(idq_pkg::OP_PUSH_BACK, '0, pick_value());
        send_beat(idq_pkg::OP_PUSH_BACK, '0, pick_value());
        send_beat(idq_pkg::OP_POP_BACK, '0, '0);
        send_beat(idq_pkg::OP_PUSH_FRONT, '0, pick_value());
        send_beat(idq_pkg::OP_PUSH_FRONT, '0, pick_value());
        send_beat(idq_pkg::OP_READ, '0, '0);
        repeat (24)
        begin
            k = $urandom_range(99);
            if (k < 30)
                op = idq_pkg::OP_POP_BACK;
            else if (k < 60)
                op = idq_pkg::OP_POP_FRONT;
            else
                op = idq_pkg::OP_READ;
            send_beat(op, pick_position(), pick_value());
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_basic_and_empty();
        test_random_traffic(120);

        send_idle_pct  = 58;
        recv_stall_pct = 0;
        test_random_traffic(120);

        send_idle_pct  = 0;
        recv_stall_pct = 58;
        test_random_traffic(120);

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        test_full_store();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
